@@ hw/rtl/page_buffer_locate_replace_unit_defines.svh @@
// Assertion helpers shared by the checker.
`ifndef PAGE_BUFFER_LOCATE_REPLACE_UNIT_DEFINES_SVH
`define PAGE_BUFFER_LOCATE_REPLACE_UNIT_DEFINES_SVH

// same-cycle implication
`define PBL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbl check failed");

// next-cycle implication
`define PBL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbl check failed");

`endif

@@ hw/rtl/pbl_pkg.sv @@
package pbl_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_W  = 3;
  localparam int STAMP_W = 31;

  localparam logic [1:0] KIND_WB    = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FILE  = 2'd1;
  localparam logic [1:0] ST_BAD_PTR  = 2'd2;
  localparam logic [1:0] ST_DEADLOCK = 2'd3;

  localparam logic [2:0] CFG_FILE_SEL = 3'd0;
  localparam logic [2:0] CFG_CUR_FILE = 3'd1;
  localparam logic [2:0] CFG_LAST_PG  = 3'd2;
  localparam logic [2:0] CFG_SLOTS    = 3'd3;
  localparam logic [2:0] CFG_RESV     = 3'd4;

  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] skip;
    logic [3:0]        n;
  } scan_ctl_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] victim;
  } scan_res_t;

endpackage

@@ hw/rtl/pbl_victim_scan.sv @@
module pbl_victim_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pbl_pkg::scan_ctl_t               ctl,
  input  logic [pbl_pkg::SLOTS-1:0]        occupied,
  input  logic [7:0]                       reserved,
  input  logic [pbl_pkg::STAMP_W-1:0]      stamp_rd,
  output logic [pbl_pkg::SLOT_W-1:0]       stamp_idx,
  output pbl_pkg::scan_res_t               res
);
  import pbl_pkg::*;

  logic              busy_r;
  logic [3:0]        idx_r;
  logic [3:0]        n_r;
  logic [SLOT_W-1:0] skip_r;
  logic              have_r;
  logic [SLOT_W-1:0] best_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic              done_r, found_r;
  logic [SLOT_W-1:0] victim_r;
  logic              elig;

  assign stamp_idx = idx_r[SLOT_W-1:0];
  assign elig = (idx_r[SLOT_W-1:0] != skip_r) && !reserved[idx_r[SLOT_W-1:0]];
  assign res = '{done: done_r, found: found_r, victim: victim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (ctl.start) begin
        done_r <= 1'b0;
        busy_r <= 1'b1;
        idx_r  <= 4'd0;
        n_r    <= ctl.n;
        skip_r <= ctl.skip;
        have_r <= 1'b0;
      end else if (busy_r) begin
        if (idx_r >= n_r) begin
          busy_r   <= 1'b0;
          done_r   <= 1'b1;
          found_r  <= have_r;
          victim_r <= best_r;
        end else if (elig && !occupied[idx_r[SLOT_W-1:0]]) begin
          // empty slot wins at once
          busy_r   <= 1'b0;
          done_r   <= 1'b1;
          found_r  <= 1'b1;
          victim_r <= idx_r[SLOT_W-1:0];
        end else begin
          done_r <= 1'b0;
          if (elig && (!have_r || stamp_rd <= best_stamp_r)) begin
            have_r       <= 1'b1;
            best_r       <= idx_r[SLOT_W-1:0];
            best_stamp_r <= stamp_rd;
          end
          idx_r <= idx_r + 4'd1;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end
endmodule

@@ hw/rtl/page_buffer_locate_replace_unit.sv @@
// Channel | Direction | Fields
// in_     | request   | page_number[9:0], page_offset[11:0]
// out_    | result    | item_kind, status, slot_index, old_occupied, io_file,
//         |           | io_page, byte_offset, last_item (one to three per request)
// cfg_    | write     | cfg_index[2:0], cfg_wdata[9:0]
// Reject: IDLE then FIN. Hit: IDLE, MAP (the registered page map read), then FIN.
// Miss: IDLE, MAP, WB, FILL, SCAN, FIN; the victim scan reads one stamp a cycle.
// After reset the page map is swept clear, all FILES*PAGES entries, with in_ready low.
// A result waiting in the output register stalls the sequencer, not the input.
module page_buffer_locate_replace_unit #(
  parameter int PAGES      = 1024,
  parameter int FILES      = 4,
  parameter int PAGE_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_page_number,
  input  logic [11:0] in_page_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_item_kind,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot_index,
  output logic        out_old_occupied,
  output logic [1:0]  out_io_file,
  output logic [9:0]  out_io_page,
  output logic [11:0] out_byte_offset,
  output logic        out_last_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);
  import pbl_pkg::*;

  localparam int MAP_DEPTH = FILES * PAGES;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r;

  logic       file_sel_r;
  logic [1:0] cur_file_r;
  logic [9:0] last_page_r;
  logic [3:0] slots_r;
  logic [7:0] resv_r;

  logic [STAMP_W-1:0] cnt_r;
  logic [STAMP_W-1:0] slot_stamp_r [SLOTS];
  logic [SLOTS-1:0]   slot_occ_r;
  logic [1:0]         slot_file_r [SLOTS];
  logic [9:0]         slot_page_r [SLOTS];
  logic [SLOT_W-1:0]  vuln_r;

  logic [3:0] map_mem [MAP_DEPTH];
  logic [3:0] map_rdata_r;
  logic [MAP_AW-1:0] map_raddr, clr_addr_r;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic [3:0]        map_wdata;

  logic [9:0]  page_r;
  logic [11:0] offset_r;
  logic [MAP_AW-1:0] mapidx_r;

  logic [1:0]        fin_status_r;
  logic [SLOT_W-1:0] fin_slot_r;
  logic [11:0]       fin_offset_r;

  logic              out_valid_r;
  logic [1:0]        kind_r, status_r, io_file_r;
  logic [2:0]        slot_out_r;
  logic              old_occ_r, last_r;
  logic [9:0]        io_page_r;
  logic [11:0]       boff_r;

  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;
  logic [SLOT_W-1:0] scan_idx;
  logic [3:0]        n_act;
  logic              can_load, in_acc, out_load;
  logic [31:0]       idx_full, old_full;
  logic [STAMP_W:0]  cnt_sum;
  logic              bad_ptr, old_in_range;
  logic [SLOT_W-1:0] vs;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign can_load  = !out_valid_r || out_ready;
  assign out_load  = can_load &&
                     ((state_r == S_WB) || (state_r == S_FILL) || (state_r == S_FIN));
  assign n_act     = (slots_r > 4'(SLOTS)) ? 4'(SLOTS) : slots_r;
  assign vs        = vuln_r;
  assign cnt_sum   = {1'b0, cnt_r} + {{STAMP_W{1'b0}}, 1'b1};

  assign idx_full  = 32'(cur_file_r) * 32'(PAGES) + 32'(in_page_number);
  assign map_raddr = idx_full[MAP_AW-1:0];
  assign old_full  = 32'(slot_file_r[vs]) * 32'(PAGES) + 32'(slot_page_r[vs]);
  assign old_in_range = (32'(slot_file_r[vs]) < 32'(FILES)) &&
                        (32'(slot_page_r[vs]) < 32'(PAGES));
  assign bad_ptr = (in_page_number > last_page_r) ||
                   (32'(in_page_number) >= 32'(PAGES)) ||
                   (32'(in_page_offset) >= 32'(PAGE_BYTES)) ||
                   (32'(cur_file_r) >= 32'(FILES));

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_addr_r;
    map_wdata = 4'd0;
    if (state_r == S_CLR) begin
      map_we = 1'b1;
    end else if (state_r == S_WB && can_load) begin
      map_we    = slot_occ_r[vs] && old_in_range;
      map_waddr = old_full[MAP_AW-1:0];
    end else if (state_r == S_FILL && can_load) begin
      map_we    = 1'b1;
      map_waddr = mapidx_r;
      map_wdata = {1'b1, vs};
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata_r <= map_mem[map_raddr];
  end

  assign scan_ctl = '{start: (state_r == S_FILL) && can_load, skip: vs, n: n_act};

  pbl_victim_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .occupied  (slot_occ_r),
    .reserved  (resv_r),
    .stamp_rd  (slot_stamp_r[scan_idx]),
    .stamp_idx (scan_idx),
    .res       (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_sel_r  <= 1'b0;
      cur_file_r  <= 2'd0;
      last_page_r <= 10'd0;
      slots_r     <= 4'd8;
      resv_r      <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILE_SEL: file_sel_r  <= cfg_wdata[0];
        CFG_CUR_FILE: cur_file_r  <= cfg_wdata[1:0];
        CFG_LAST_PG:  last_page_r <= cfg_wdata;
        CFG_SLOTS:    slots_r     <= cfg_wdata[3:0];
        CFG_RESV:     resv_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      slot_occ_r  <= '0;
      vuln_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_stamp_r[i] <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + MAP_AW'(1);
          if (clr_addr_r == MAP_AW'(MAP_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            page_r       <= in_page_number;
            offset_r     <= in_page_offset;
            mapidx_r     <= map_raddr;
            fin_slot_r   <= '0;
            fin_offset_r <= 12'd0;
            if (!file_sel_r) begin
              fin_status_r <= ST_NO_FILE;
              state_r      <= S_FIN;
            end else if (bad_ptr) begin
              fin_status_r <= ST_BAD_PTR;
              state_r      <= S_FIN;
            end else begin
              // advance; on overflow restart at one and drop active stamps
              if (cnt_sum[STAMP_W]) begin
                cnt_r <= STAMP_W'(1);
                for (int i = 0; i < SLOTS; i++)
                  if (4'(i) < n_act) slot_stamp_r[i] <= '0;
              end else begin
                cnt_r <= cnt_sum[STAMP_W-1:0];
              end
              state_r <= S_MAP;
            end
          end
        end
        S_MAP: begin
          if (map_rdata_r[3]) begin
            slot_stamp_r[map_rdata_r[SLOT_W-1:0]] <= cnt_r;
            fin_status_r <= ST_OK;
            fin_slot_r   <= map_rdata_r[SLOT_W-1:0];
            fin_offset_r <= offset_r;
            state_r      <= S_FIN;
          end else begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          if (can_load) begin
            kind_r      <= KIND_WB;
            status_r    <= ST_OK;
            slot_out_r  <= vs;
            old_occ_r   <= slot_occ_r[vs];
            io_file_r   <= slot_occ_r[vs] ? slot_file_r[vs] : 2'd0;
            io_page_r   <= slot_occ_r[vs] ? slot_page_r[vs] : 10'd0;
            boff_r      <= 12'd0;
            last_r      <= 1'b0;
            state_r     <= S_FILL;
          end
        end
        S_FILL: begin
          if (can_load) begin
            kind_r          <= KIND_FILL;
            status_r        <= ST_OK;
            slot_out_r      <= vs;
            old_occ_r       <= 1'b0;
            io_file_r       <= cur_file_r;
            io_page_r       <= page_r;
            boff_r          <= 12'd0;
            last_r          <= 1'b0;
            slot_occ_r[vs]  <= 1'b1;
            slot_file_r[vs] <= cur_file_r;
            slot_page_r[vs] <= page_r;
            state_r         <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            fin_slot_r <= vs;
            if (scan_res.found) begin
              vuln_r           <= scan_res.victim;
              slot_stamp_r[vs] <= cnt_r;
              fin_status_r     <= ST_OK;
              fin_offset_r     <= offset_r;
            end else begin
              fin_status_r <= ST_DEADLOCK;
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (can_load) begin
            kind_r      <= KIND_FINAL;
            status_r    <= fin_status_r;
            slot_out_r  <= fin_slot_r;
            old_occ_r   <= 1'b0;
            io_file_r   <= 2'd0;
            io_page_r   <= 10'd0;
            boff_r      <= fin_offset_r;
            last_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = kind_r;
  assign out_status       = status_r;
  assign out_slot_index   = slot_out_r;
  assign out_old_occupied = old_occ_r;
  assign out_io_file      = io_file_r;
  assign out_io_page      = io_page_r;
  assign out_byte_offset  = boff_r;
  assign out_last_item    = last_r;
endmodule

@@ hw/rtl/pbl_checker.sv @@
`include "page_buffer_locate_replace_unit_defines.svh"

module pbl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_item_kind,
  input logic [1:0]  out_io_file,
  input logic [9:0]  out_io_page,
  input logic        out_old_occupied,
  input logic        out_last_item
);
  import pbl_pkg::*;

  `PBL_ASSERT_NOW(a_last_is_final, out_valid, (out_item_kind == KIND_FINAL) == out_last_item)
  `PBL_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `PBL_ASSERT_NOW(a_empty_wb_zero, out_valid && out_item_kind == KIND_WB && !out_old_occupied, out_io_file == 2'd0 && out_io_page == 10'd0)
  `PBL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item_kind))
endmodule

bind page_buffer_locate_replace_unit pbl_checker u_pbl_checker (.*);

@@ tb/page_buffer_locate_replace_unit_test.sv @@
module page_buffer_locate_replace_unit_test;
  import pbl_pkg::*;

  localparam int PAGES      = 1024;
  localparam int FILES      = 4;
  localparam int PAGE_BYTES = 2048;
  localparam int SETTLE     = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [2:0]  slot;
    logic        occ;
    logic [1:0]  file;
    logic [9:0]  page;
    logic [11:0] offset;
    logic        last;
  } locate_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [9:0]  in_page_number = '0;
  logic [11:0] in_page_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_item_kind;
  logic [1:0]  out_status;
  logic [2:0]  out_slot_index;
  logic        out_old_occupied;
  logic [1:0]  out_io_file;
  logic [9:0]  out_io_page;
  logic [11:0] out_byte_offset;
  logic        out_last_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_wdata = '0;

  page_buffer_locate_replace_unit #(
    .PAGES(PAGES), .FILES(FILES), .PAGE_BYTES(PAGE_BYTES)
  ) dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the block
  logic        file_sel;
  logic [1:0]  cur_file;
  logic [9:0]  last_pg;
  logic [3:0]  slot_count;
  logic [7:0]  resv_mask;
  int unsigned locate_count;
  int unsigned stamp [SLOTS];
  bit          occupied [SLOTS];
  logic [1:0]  held_file [SLOTS];
  logic [9:0]  held_page [SLOTS];
  bit          map_valid [FILES*PAGES];
  logic [2:0]  map_slot [FILES*PAGES];
  int unsigned victim_slot;

  locate_result_t pending_results[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;

  function automatic int unsigned active_count();
    return (slot_count > SLOTS) ? SLOTS : slot_count;
  endfunction

  // first empty unreserved slot, else least stamp, last on ties; SLOTS if none
  function automatic int unsigned choose_victim(int unsigned skip);
    int unsigned best;
    best = SLOTS;
    for (int unsigned i = 0; i < active_count(); i++) begin
      if (i == skip || resv_mask[i]) continue;
      if (!occupied[i]) return i;
      if (best == SLOTS || stamp[i] <= stamp[best]) best = i;
    end
    return best;
  endfunction

  function automatic locate_result_t mk(logic [1:0] k, logic [1:0] st, int unsigned s,
                                        logic o, logic [1:0] f, logic [9:0] p,
                                        logic [11:0] off, logic l);
    locate_result_t r;
    r = '{k, st, s[2:0], o, f, p, off, l};
    return r;
  endfunction

  task automatic predict_locate(logic [9:0] pg, logic [11:0] off);
    int unsigned idx, target, s, v;
    if (!file_sel) begin
      pending_results.push_back(mk(KIND_FINAL, ST_NO_FILE, 0, 0, 0, 0, 0, 1));
      return;
    end
    if (pg > last_pg || off >= PAGE_BYTES) begin
      pending_results.push_back(mk(KIND_FINAL, ST_BAD_PTR, 0, 0, 0, 0, 0, 1));
      return;
    end
    locate_count++;
    if (locate_count >= 32'h8000_0000 || locate_count == 0) begin
      locate_count = 1;
      for (int unsigned i = 0; i < active_count(); i++) stamp[i] = 0;
    end
    idx = cur_file * PAGES + pg;
    if (map_valid[idx]) begin
      target = map_slot[idx];
    end else begin
      s = victim_slot % SLOTS;
      if (occupied[s]) begin
        pending_results.push_back(mk(KIND_WB, ST_OK, s, 1, held_file[s], held_page[s], 0, 0));
        map_valid[held_file[s] * PAGES + held_page[s]] = 1'b0;
      end else begin
        pending_results.push_back(mk(KIND_WB, ST_OK, s, 0, 0, 0, 0, 0));
      end
      pending_results.push_back(mk(KIND_FILL, ST_OK, s, 0, cur_file, pg, 0, 0));
      occupied[s] = 1'b1;
      held_file[s] = cur_file;
      held_page[s] = pg;
      map_valid[idx] = 1'b1;
      map_slot[idx] = s[2:0];
      target = s;
      v = choose_victim(s);
      if (v >= SLOTS) begin
        pending_results.push_back(mk(KIND_FINAL, ST_DEADLOCK, s, 0, 0, 0, 0, 1));
        return;
      end
      victim_slot = v;
    end
    stamp[target] = locate_count;
    pending_results.push_back(mk(KIND_FINAL, ST_OK, target, 0, 0, 0, off, 1));
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  // result checker and receiver pacing
  always @(posedge clk) begin
    locate_result_t got, want;
    if (out_valid && out_ready) begin
      got = '{out_item_kind, out_status, out_slot_index, out_old_occupied,
              out_io_file, out_io_page, out_byte_offset, out_last_item};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          report_mismatch($sformatf("got %p, want %p", got, want));
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_request(logic [9:0] pg, logic [11:0] off);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page_number <= pg;
    in_page_offset <= off;
    do @(posedge clk); while (!in_ready);
    predict_locate(pg, off);
  endtask

  // drop valid and wait for every pending result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FILE_SEL: file_sel = val[0];
      CFG_CUR_FILE: cur_file = val[1:0];
      CFG_LAST_PG:  last_pg = val;
      CFG_SLOTS:    slot_count = val[3:0];
      CFG_RESV:     resv_mask = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic setup(logic sel, logic [1:0] f, logic [9:0] lp, logic [3:0] n,
                       logic [7:0] m);
    drain();
    write_reg(CFG_FILE_SEL, {9'd0, sel});
    write_reg(CFG_CUR_FILE, {8'd0, f});
    write_reg(CFG_LAST_PG, lp);
    write_reg(CFG_SLOTS, {6'd0, n});
    write_reg(CFG_RESV, {2'd0, m});
  endtask

  task automatic test_no_file();
    send_request(10'd0, 12'd0);
    send_request(10'd1023, 12'd4095);
    // unused register indexes must change nothing
    drain();
    write_reg(3'd5, 10'h3ff);
    write_reg(3'd7, 10'h155);
    send_request(10'd5, 12'd100);
  endtask

  task automatic test_bad_pointer();
    setup(1, 2'd3, 10'd5, 4'd8, 8'h00);
    send_request(10'd6, 12'd0);
    send_request(10'd1023, 12'd0);
    send_request(10'd0, 12'd2048);
    send_request(10'd5, 12'd4095);
  endtask

  task automatic test_hit_miss();
    setup(1, 2'd0, 10'd1023, 4'd8, 8'h00);
    send_request(10'd0, 12'd0);
    send_request(10'd0, 12'd2047);
    send_request(10'd1023, 12'd1);
    for (int i = 1; i <= 9; i++) send_request(i[9:0], 12'(i * 200));
    send_request(10'd1023, 12'd7);
  endtask

  task automatic test_deadlock_and_stale();
    setup(1, 2'd2, 10'd1023, 4'd1, 8'h00);
    send_request(10'd40, 12'd3);
    send_request(10'd41, 12'd4);
    setup(1, 2'd2, 10'd1023, 4'd0, 8'h00);
    send_request(10'd42, 12'd5);
    setup(1, 2'd1, 10'd1023, 4'd15, 8'hff);
    send_request(10'd43, 12'd6);
    send_request(10'd44, 12'd6);
  endtask

  task automatic test_random_phase(int items);
    for (int ph = 0; ph < items / 20; ph++) begin
      setup($urandom_range(9) != 0, $urandom_range(3),
            $urandom_range(3) == 0 ? $urandom_range(1023) : 10'd1023,
            $urandom_range(2) == 0 ? $urandom_range(15) : 4'd8,
            $urandom_range(2) == 0 ? $urandom_range(255) : 8'h00);
      for (int i = 0; i < 20; i++)
        send_request($urandom_range(4) == 0 ? $urandom_range(1023) : $urandom_range(15),
                     $urandom_range(6) == 0 ? $urandom_range(4095) : $urandom_range(2047));
    end
  endtask

  task automatic test_backpressure();
    setup(1, 2'd1, 10'd1023, 4'd8, 8'h00);
    send_idle = 0;
    hold_req <= ~hold_req;
    for (int i = 0; i < 15; i++) send_request($urandom_range(31), $urandom_range(2047));
    drain();
  endtask

  initial begin
    file_sel = 0; cur_file = 0; last_pg = 0; slot_count = 8; resv_mask = 0;
    locate_count = 0; victim_slot = 0;
    foreach (stamp[i]) begin stamp[i] = 0; occupied[i] = 0; end
    foreach (map_valid[i]) map_valid[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_file();
    test_bad_pointer();
    test_hit_miss();
    test_deadlock_and_stale();
    send_idle = 37; recv_idle = 63;
    test_random_phase(160);
    send_idle = 63; recv_idle = 37;
    test_random_phase(160);
    send_idle = 0; recv_idle = 0;
    test_random_phase(160);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("page_buffer_locate_replace_unit test passed");
    end else begin
      $display("page_buffer_locate_replace_unit test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("page_buffer_locate_replace_unit test failed");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pbl_pkg.sv
hw/rtl/pbl_victim_scan.sv
hw/rtl/page_buffer_locate_replace_unit.sv
hw/rtl/pbl_checker.sv
tb/page_buffer_locate_replace_unit_test.sv
